>>> hw/rtl/vrt_pkg.sv
package vrt_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_CARVING     = 3'd0;
    localparam logic [2:0] CFG_MAX_LEN     = 3'd1;
    localparam logic [2:0] CFG_VOXEL_INV   = 3'd2;
    localparam logic [2:0] CFG_BAND        = 3'd3;
    localparam logic [2:0] CFG_FROM_ORIGIN = 3'd4;

    // Configuration reset values
    localparam logic        CARVING_RST     = 1'b1;
    localparam logic [30:0] MAX_LEN_RST     = 31'd327680;
    localparam logic [30:0] VOXEL_INV_RST   = 31'd1310720;
    localparam logic [30:0] BAND_RST        = 31'd6554;
    localparam logic        FROM_ORIGIN_RST = 1'b1;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    // Step direction codes
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_PLUS  = 2'd1;
    localparam logic [1:0] DIR_MINUS = 2'd3;

    // 2.0 in Q8.24
    localparam logic [31:0] TWO_Q24 = 32'h0200_0000;

    // Divider operand width
    localparam int DIV_W = 64;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic             cmd;
        logic [2:0][31:0] origin;
        logic [2:0][31:0] point;
        logic             clearing;
    } item_t;

    typedef struct packed {
        logic        carving;
        logic [30:0] max_len;
        logic [30:0] voxel_inv;
        logic [30:0] band;
        logic        from_origin;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hw/rtl/vrt_front.sv
module vrt_front
    import vrt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               clearing,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           mem [DEPTH];
    item_t           item_in;
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pack the incoming transaction
    always_comb
    begin
        item_in.cmd      = cmd;
        item_in.origin   = {origin_z, origin_y, origin_x};
        item_in.point    = {point_z, point_y, point_x};
        item_in.clearing = clearing;
    end

    assign in_stall = (count_reg == CW'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem[rd_ptr_reg];

    // Store the item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/vrt_div.sv
module vrt_div
    import vrt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNTW = $clog2(DIV_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  dvs_reg;
    logic [DIV_W:0]    rem_sh;
    logic [DIV_W+1:0]  trial;

    // One restoring step: shift in the next dividend bit, try a subtract
    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNTW'(DIV_W - 1);
                    rem_reg  <= '0;
                    quo_reg  <= req.dividend;
                    dvs_reg  <= req.divisor;
                end
            end
            else
            begin
                if (!trial[DIV_W+1])
                begin
                    rem_reg <= trial[DIV_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[DIV_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/vrt_back.sv
module vrt_back
    import vrt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    input  cfg_t               cfg,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] voxel_x,
    output logic signed [31:0] voxel_y,
    output logic signed [31:0] voxel_z,
    output logic               valid_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_OFF, S_POS, S_SCALE, S_AXIS, S_DIVW, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        K_OFF, K_TCROSS, K_TINC
    } div_kind_t;

    state_t      state_reg;
    div_kind_t   kind_reg;
    logic [1:0]  ax_reg;
    logic        ph_reg;
    logic        side_reg;
    logic [5:0]  cnt_reg;

    // Load working registers
    logic [31:0] o_reg [3];
    logic [31:0] p_reg [3];
    logic [32:0] d_reg [3];
    logic        clr_reg;
    logic [65:0] sum_reg;
    logic [65:0] sq_reg;
    logic [32:0] root_reg;
    logic [34:0] rem_reg;
    logic [32:0] len_l_reg;
    logic [30:0] len_reg;
    logic [33:0] off_reg [3];
    logic [35:0] pa_reg [3];
    logic [35:0] pb_reg [3];
    logic [63:0] sa_reg [3];
    logic [63:0] sb_reg [3];
    logic [34:0] total_reg;
    logic [63:0] m_reg;
    logic [67:0] prod_reg;
    div_req_t    div_req_reg;
    div_rsp_t    div_rsp;

    // Traversal state
    logic [31:0] vox_reg [3];
    logic [1:0]  dir_reg [3];
    logic [31:0] ncross_reg [3];
    logic [31:0] cinc_reg [3];
    logic [31:0] steps_taken_reg;
    logic [31:0] steps_total_reg;
    logic        ray_empty_reg;

    // Result register
    logic        out_valid_reg;
    logic [31:0] out_vox_reg [3];
    logic        valid_res_reg;

    logic        out_free;
    logic [32:0] d_in [3];
    logic        moving;
    logic [33:0] mul_a;
    logic [33:0] mul_b;
    logic [65:0] sum_next;
    logic [1:0]  pair;
    logic [36:0] rem_sh;
    logic [36:0] sq_trial;
    logic [32:0] root_next;
    logic [34:0] rem_next;
    logic [34:0] lenw;
    logic [30:0] len_clear;
    logic [35:0] pos_a [3];
    logic [35:0] pos_b [3];
    logic [35:0] scale_v;
    logic [35:0] scale_mag;
    logic [63:0] scaled;
    logic [63:0] ax_a;
    logic [63:0] ax_b;
    logic [32:0] di;
    logic [32:0] gap;
    logic [1:0]  k;
    logic [32:0] cross_sum;
    logic [31:0] cross_sat;

    function automatic logic [32:0] mag33(input logic [32:0] v);
        mag33 = v[32] ? (~v + 33'd1) : v;
    endfunction

    function automatic logic [35:0] mag36(input logic [35:0] v);
        mag36 = v[35] ? (~v + 36'd1) : v;
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] q);
        sat32 = (q[63:32] != '0) ? '1 : q[31:0];
    endfunction

    vrt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == S_IDLE) && q_valid
                       && ((q_item.cmd == CMD_LOAD) || out_free);
    assign out_valid = out_valid_reg;
    assign voxel_x   = out_vox_reg[0];
    assign voxel_y   = out_vox_reg[1];
    assign voxel_z   = out_vox_reg[2];
    assign valid_res = valid_res_reg;

    // Ray direction of the incoming load
    always_comb
    begin
        moving = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d_in[i] = {q_item.point[i][31], q_item.point[i]}
                      - {q_item.origin[i][31], q_item.origin[i]};
            if (d_in[i] != '0)
            begin
                moving = 1'b1;
            end
        end
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        scale_v   = side_reg ? pb_reg[ax_reg] : pa_reg[ax_reg];
        scale_mag = mag36(scale_v);
        case (state_reg)
            S_SQ:
            begin
                mul_a = {1'b0, mag33(d_reg[ax_reg])};
                mul_b = {1'b0, mag33(d_reg[ax_reg])};
            end
            S_OFF:
            begin
                mul_a = {1'b0, mag33(d_reg[ax_reg])};
                mul_b = {3'b000, len_reg};
            end
            S_SCALE:
            begin
                mul_a = scale_mag[33:0];
                mul_b = {3'b000, cfg.voxel_inv};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Square root step and clearing length
    always_comb
    begin
        sum_next  = sum_reg + {1'b0, prod_reg[64:0]};
        pair      = sq_reg[65:64];
        rem_sh    = {rem_reg, pair};
        sq_trial  = {2'b00, root_reg[32:0], 2'b01};
        if (rem_sh >= sq_trial)
        begin
            rem_next  = 35'(rem_sh - sq_trial);
            root_next = {root_reg[31:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh[34:0];
            root_next = {root_reg[31:0], 1'b0};
        end
        lenw = {2'b00, len_l_reg} - {4'b0000, cfg.band};
        if (lenw[34])
        begin
            len_clear = '0;
        end
        else if (lenw[33:0] > {3'b000, cfg.max_len})
        begin
            len_clear = cfg.max_len;
        end
        else
        begin
            len_clear = lenw[30:0];
        end
    end

    // Segment end points per axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [35:0] o36;
            logic [35:0] p36;
            logic [35:0] f36;
            logic [35:0] en;
            logic [35:0] st;
            o36 = {{4{o_reg[i][31]}}, o_reg[i]};
            p36 = {{4{p_reg[i][31]}}, p_reg[i]};
            f36 = {{2{off_reg[i][33]}}, off_reg[i]};
            if (clr_reg)
            begin
                en = o36 + f36;
                st = cfg.carving ? o36 : en;
            end
            else
            begin
                en = p36 + f36;
                st = cfg.carving ? o36 : (p36 - f36);
            end
            pos_a[i] = cfg.from_origin ? st : en;
            pos_b[i] = cfg.from_origin ? en : st;
        end
    end

    // Axis setup terms
    always_comb
    begin
        scaled = scale_v[35] ? (~prod_reg[63:0] + 64'd1) : prod_reg[63:0];
        ax_a   = sa_reg[ax_reg];
        ax_b   = sb_reg[ax_reg];
        di     = {ax_b[63], ax_b[63:32]} - {ax_a[63], ax_a[63:32]};
        if ($signed(ax_b) > $signed(ax_a))
        begin
            gap = 33'h1_0000_0000 - {1'b0, ax_a[31:0]};
        end
        else
        begin
            gap = {1'b0, ax_a[31:0]};
        end
    end

    // Pick the axis with the earliest crossing, lowest axis on ties
    always_comb
    begin
        k = 2'd0;
        if (ncross_reg[1] < ncross_reg[0])
        begin
            k = 2'd1;
        end
        if (ncross_reg[2] < ncross_reg[k])
        begin
            k = 2'd2;
        end
        cross_sum = {1'b0, ncross_reg[k]} + {1'b0, cinc_reg[k]};
        cross_sat = cross_sum[32] ? '1 : cross_sum[31:0];
    end

    // Sequencer, traversal state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            kind_reg        <= K_OFF;
            ax_reg          <= '0;
            ph_reg          <= 1'b0;
            side_reg        <= 1'b0;
            cnt_reg         <= '0;
            clr_reg         <= 1'b0;
            sum_reg         <= '0;
            sq_reg          <= '0;
            root_reg        <= '0;
            rem_reg         <= '0;
            len_l_reg       <= '0;
            len_reg         <= '0;
            total_reg       <= '0;
            m_reg           <= '0;
            div_req_reg     <= '0;
            steps_taken_reg <= '0;
            steps_total_reg <= '0;
            ray_empty_reg   <= 1'b1;
            out_valid_reg   <= 1'b0;
            valid_res_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                o_reg[i]       <= '0;
                p_reg[i]       <= '0;
                d_reg[i]       <= '0;
                off_reg[i]     <= '0;
                pa_reg[i]      <= '0;
                pb_reg[i]      <= '0;
                sa_reg[i]      <= '0;
                sb_reg[i]      <= '0;
                vox_reg[i]     <= '0;
                dir_reg[i]     <= DIR_NONE;
                ncross_reg[i]  <= '0;
                cinc_reg[i]    <= '0;
                out_vox_reg[i] <= '0;
            end
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && (q_item.cmd == CMD_NEXT))
                    begin
                        // Deliver the current voxel, then step
                        out_valid_reg <= 1'b1;
                        if (ray_empty_reg)
                        begin
                            valid_res_reg <= 1'b0;
                            for (int i = 0; i < 3; i++)
                            begin
                                out_vox_reg[i] <= '0;
                            end
                        end
                        else
                        begin
                            valid_res_reg <= 1'b1;
                            for (int i = 0; i < 3; i++)
                            begin
                                out_vox_reg[i] <= vox_reg[i];
                            end
                            if (dir_reg[k] == DIR_PLUS)
                            begin
                                vox_reg[k] <= vox_reg[k] + 32'd1;
                            end
                            else if (dir_reg[k] == DIR_MINUS)
                            begin
                                vox_reg[k] <= vox_reg[k] - 32'd1;
                            end
                            ncross_reg[k] <= cross_sat;
                            if (steps_taken_reg >= steps_total_reg)
                            begin
                                ray_empty_reg <= 1'b1;
                            end
                            else
                            begin
                                steps_taken_reg <= steps_taken_reg + 32'd1;
                            end
                        end
                    end
                    else if (q_pop)
                    begin
                        // Latch a new ray
                        for (int i = 0; i < 3; i++)
                        begin
                            o_reg[i] <= q_item.origin[i];
                            p_reg[i] <= q_item.point[i];
                            d_reg[i] <= d_in[i];
                        end
                        clr_reg         <= q_item.clearing;
                        steps_taken_reg <= '0;
                        steps_total_reg <= '0;
                        if (!moving)
                        begin
                            ray_empty_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_SQ;
                            ax_reg    <= '0;
                            ph_reg    <= 1'b0;
                            sum_reg   <= '0;
                        end
                    end
                end

                S_SQ:
                begin
                    // Accumulate the squared components
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        sum_reg <= sum_next;
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= S_SQRT;
                            sq_reg    <= sum_next;
                            cnt_reg   <= 6'd32;
                            root_reg  <= '0;
                            rem_reg   <= '0;
                        end
                        else
                        begin
                            ax_reg <= ax_reg + 2'd1;
                        end
                    end
                end

                S_SQRT:
                begin
                    // One root bit per cycle
                    sq_reg   <= {sq_reg[63:0], 2'b00};
                    root_reg <= root_next;
                    rem_reg  <= rem_next;
                    cnt_reg  <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        len_l_reg <= root_next;
                        state_reg <= S_POS;
                        ph_reg    <= 1'b1;
                    end
                end

                S_OFF:
                begin
                    // Offset along the ray: rounded |d|*len/L
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= prod_reg[63:0]
                                                + {32'd0, len_l_reg[32:1]};
                        div_req_reg.divisor  <= {31'd0, len_l_reg};
                        kind_reg             <= K_OFF;
                        state_reg            <= S_DIVW;
                    end
                end

                S_POS:
                begin
                    if (ph_reg)
                    begin
                        // Choose the offset length once the norm is known
                        len_reg   <= clr_reg ? len_clear : cfg.band;
                        ph_reg    <= 1'b0;
                        ax_reg    <= '0;
                        state_reg <= S_OFF;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            pa_reg[i] <= pos_a[i];
                            pb_reg[i] <= pos_b[i];
                        end
                        state_reg <= S_SCALE;
                        ax_reg    <= '0;
                        side_reg  <= 1'b0;
                    end
                end

                S_SCALE:
                begin
                    // Scale both end points to voxel units
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (side_reg)
                        begin
                            sb_reg[ax_reg] <= scaled;
                            side_reg       <= 1'b0;
                            if (ax_reg == 2'd2)
                            begin
                                state_reg <= S_AXIS;
                                ax_reg    <= '0;
                                total_reg <= '0;
                            end
                            else
                            begin
                                ax_reg <= ax_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            sa_reg[ax_reg] <= scaled;
                            side_reg       <= 1'b1;
                        end
                    end
                end

                S_AXIS:
                begin
                    vox_reg[ax_reg] <= ax_a[63:32];
                    total_reg       <= total_reg + {2'b00, mag33(di)};
                    if (ax_b == ax_a)
                    begin
                        dir_reg[ax_reg]    <= DIR_NONE;
                        ncross_reg[ax_reg] <= TWO_Q24;
                        cinc_reg[ax_reg]   <= TWO_Q24;
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            ax_reg <= ax_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        if ($signed(ax_b) > $signed(ax_a))
                        begin
                            dir_reg[ax_reg] <= DIR_PLUS;
                            m_reg           <= ax_b - ax_a;
                            div_req_reg.divisor <= ax_b - ax_a;
                        end
                        else
                        begin
                            dir_reg[ax_reg] <= DIR_MINUS;
                            m_reg           <= ax_a - ax_b;
                            div_req_reg.divisor <= ax_a - ax_b;
                        end
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= {7'd0, gap, 24'd0};
                        kind_reg             <= K_TCROSS;
                        state_reg            <= S_DIVW;
                    end
                end

                S_DIVW:
                begin
                    if (div_rsp.done)
                    begin
                        case (kind_reg)
                            K_OFF:
                            begin
                                off_reg[ax_reg] <= d_reg[ax_reg][32]
                                    ? (~div_rsp.quotient[33:0] + 34'd1)
                                    : div_rsp.quotient[33:0];
                                ph_reg <= 1'b0;
                                if (ax_reg == 2'd2)
                                begin
                                    state_reg <= S_POS;
                                end
                                else
                                begin
                                    ax_reg    <= ax_reg + 2'd1;
                                    state_reg <= S_OFF;
                                end
                            end
                            K_TCROSS:
                            begin
                                ncross_reg[ax_reg]   <= sat32(div_rsp.quotient);
                                div_req_reg.start    <= 1'b1;
                                div_req_reg.dividend <= 64'h0100_0000_0000_0000;
                                div_req_reg.divisor  <= m_reg;
                                kind_reg             <= K_TINC;
                            end
                            default:
                            begin
                                cinc_reg[ax_reg] <= sat32(div_rsp.quotient);
                                if (ax_reg == 2'd2)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    ax_reg    <= ax_reg + 2'd1;
                                    state_reg <= S_AXIS;
                                end
                            end
                        endcase
                    end
                end

                S_DONE:
                begin
                    steps_total_reg <= (total_reg[34:32] != '0) ? '1 : total_reg[31:0];
                    ray_empty_reg   <= 1'b0;
                    state_reg       <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !ray_empty_reg |-> (steps_taken_reg <= steps_total_reg))
        else $error("steps taken ran past the ray length");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIVW))
        else $error("divider finished while the sequencer was not waiting");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && (state_reg == S_IDLE)))
        else $error("queue popped outside idle or while empty");

    a_dir_codes: assert property (@(posedge clk) disable iff (!rst_n)
        (dir_reg[0] != 2'b10) && (dir_reg[1] != 2'b10) && (dir_reg[2] != 2'b10))
        else $error("reserved step direction code");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (q_item.cmd == CMD_LOAD) && !out_valid_reg) |=> !out_valid_reg)
        else $error("a load produced a result");
`endif

endmodule

>>> hw/rtl/voxel_ray_traversal.sv
// Voxel ray traversal engine.
// Input channel (in_valid/in_stall): cmd 0 loads a ray from origin and point
// (Q16.16 meters) with the clearing flag; cmd 1 asks for the next voxel.
// Output channel (out_valid/out_stall): one transaction per next command with
// voxel_x/y/z and valid_res; a load returns nothing.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while the engine is idle.
// A front queue takes commands while the back end is busy, so a load can be
// followed by next commands without waiting on the sender side.
// Next command: the result is registered in the queue and then in the output
// register; one per cycle while the back end is idle and not stalled. A load
// runs a serial divider (up to nine quotients) and a bit-serial square root.
// When the receiver stalls, the result is held in the output register; the
// back end takes no next command, the queue fills, then in_stall rises.
// Reset clears the queue, loads default configuration and leaves no ray
// loaded, so next commands return valid_res 0 with zero indexes.
module voxel_ray_traversal
    import vrt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               clearing,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] voxel_x,
    output logic signed [31:0] voxel_y,
    output logic signed [31:0] voxel_z,
    output logic               valid_res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    cfg_t   cfg_reg;
    logic   q_valid;
    item_t  q_item;
    logic   q_pop;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carving     <= CARVING_RST;
            cfg_reg.max_len     <= MAX_LEN_RST;
            cfg_reg.voxel_inv   <= VOXEL_INV_RST;
            cfg_reg.band        <= BAND_RST;
            cfg_reg.from_origin <= FROM_ORIGIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CARVING:     cfg_reg.carving     <= cfg_data[0];
                CFG_MAX_LEN:     cfg_reg.max_len     <= cfg_data;
                CFG_VOXEL_INV:   cfg_reg.voxel_inv   <= cfg_data;
                CFG_BAND:        cfg_reg.band        <= cfg_data;
                CFG_FROM_ORIGIN: cfg_reg.from_origin <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    vrt_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .origin_z (origin_z),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    vrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .voxel_x   (voxel_x),
        .voxel_y   (voxel_y),
        .voxel_z   (voxel_z),
        .valid_res (valid_res)
    );

endmodule

>>> dv/tb_voxel_ray_traversal.sv
module tb_voxel_ray_traversal;
    import vrt_pkg::*;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        hit;
    } voxel_res_t;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               cmd;
    logic signed [31:0] origin_x, origin_y, origin_z;
    logic signed [31:0] point_x, point_y, point_z;
    logic               clearing;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] voxel_x, voxel_y, voxel_z;
    logic               valid_res;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [30:0]        cfg_data;

    // Shadow configuration
    logic        sh_carving;
    logic [30:0] sh_max_len;
    logic [30:0] sh_voxel_inv;
    logic [30:0] sh_band;
    logic        sh_from_origin;

    // Shadow traversal state
    logic [31:0] walk_voxel [3];
    logic [1:0]  walk_dir [3];
    logic [31:0] walk_cross [3];
    logic [31:0] walk_inc [3];
    logic [31:0] walk_taken;
    logic [31:0] walk_total;
    logic        walk_done;

    voxel_res_t  voxel_queue[$];
    int          errors;
    int          idle_pct;
    int          stall_pct;
    int          hold_left;
    int          quiet_cycles;
    int          n_loads;
    int          n_nexts;
    int          n_checked;
    int          n_cfg;

    voxel_ray_traversal DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .origin_z  (origin_z),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .voxel_x   (voxel_x),
        .voxel_y   (voxel_y),
        .voxel_z   (voxel_z),
        .valid_res (valid_res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offset of length ln along one axis of a ray of length ray_len
    function automatic longint axis_offset(longint dd, logic [63:0] ln, logic [63:0] ray_len);
        logic [63:0] mg;
        logic [63:0] q;
        mg = (dd < 0) ? -dd : dd;
        q = (mg * ln + ray_len / 2) / ray_len;
        return (dd < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Scale a Q16.16 position to Q.32 voxel units
    function automatic logic [63:0] scale_to_voxels(longint pos);
        logic [63:0] mg;
        logic [63:0] prod;
        mg = (pos < 0) ? -pos : pos;
        prod = mg * {33'd0, sh_voxel_inv};
        return (pos < 0) ? -prod : prod;
    endfunction

    // Build the ray segment and crossing times for one load
    task automatic setup_ray(input logic [31:0] ox, oy, oz, px, py, pz, input logic clr);
        longint      o [3];
        longint      p [3];
        longint      d [3];
        longint      st [3];
        longint      en [3];
        logic [63:0] a [3];
        logic [63:0] b [3];
        logic [127:0] sumsq;
        logic [63:0] mg;
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        logic [63:0] ray_len;
        logic [63:0] span;
        logic [63:0] gap;
        logic [63:0] t;
        logic [63:0] inc;
        logic [63:0] tot;
        longint      len;
        longint      off;
        longint      di;
        bit          moving;
        o[0] = longint'($signed(ox));
        o[1] = longint'($signed(oy));
        o[2] = longint'($signed(oz));
        p[0] = longint'($signed(px));
        p[1] = longint'($signed(py));
        p[2] = longint'($signed(pz));
        moving = 1'b0;
        sumsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = p[i] - o[i];
            if (d[i] != 0)
                moving = 1'b1;
            mg = (d[i] < 0) ? -d[i] : d[i];
            sumsq = sumsq + {64'd0, mg} * {64'd0, mg};
        end
        walk_taken = '0;
        walk_total = '0;
        if (!moving)
        begin
            walk_done = 1'b1;
            return;
        end
        walk_done = 1'b0;

        // Bit-serial integer square root
        root = '0;
        rem = '0;
        for (int k = 32; k >= 0; k--)
        begin
            rem = (rem << 2) | 64'((sumsq >> (2 * k)) & 128'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        ray_len = root;

        for (int i = 0; i < 3; i++)
        begin
            if (clr)
            begin
                len = longint'(ray_len) - longint'({33'd0, sh_band});
                if (len < 0)
                    len = 0;
                if (len > longint'({33'd0, sh_max_len}))
                    len = longint'({33'd0, sh_max_len});
                en[i] = o[i] + axis_offset(d[i], 64'(len), ray_len);
                st[i] = sh_carving ? o[i] : en[i];
            end
            else
            begin
                off = axis_offset(d[i], {33'd0, sh_band}, ray_len);
                en[i] = p[i] + off;
                st[i] = sh_carving ? o[i] : p[i] - off;
            end
            a[i] = scale_to_voxels(sh_from_origin ? st[i] : en[i]);
            b[i] = scale_to_voxels(sh_from_origin ? en[i] : st[i]);
        end

        tot = '0;
        for (int i = 0; i < 3; i++)
        begin
            di = longint'($signed(b[i][63:32])) - longint'($signed(a[i][63:32]));
            walk_voxel[i] = a[i][63:32];
            tot = tot + ((di < 0) ? -di : di);
            if (b[i] == a[i])
            begin
                walk_dir[i] = DIR_NONE;
                walk_cross[i] = TWO_Q24;
                walk_inc[i] = TWO_Q24;
            end
            else
            begin
                if ($signed(b[i]) > $signed(a[i]))
                begin
                    span = b[i] - a[i];
                    walk_dir[i] = DIR_PLUS;
                    gap = (64'd1 << 32) - {32'd0, a[i][31:0]};
                end
                else
                begin
                    span = a[i] - b[i];
                    walk_dir[i] = DIR_MINUS;
                    gap = {32'd0, a[i][31:0]};
                end
                t = (gap << 24) / span;
                inc = (64'd1 << 56) / span;
                walk_cross[i] = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
                walk_inc[i] = (inc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : inc[31:0];
            end
        end
        walk_total = (tot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot[31:0];
    endtask

    // Return the current voxel and advance along the earliest crossing
    task automatic step_ray(output voxel_res_t r);
        int          k;
        logic [32:0] t;
        if (walk_done)
        begin
            r = '0;
            return;
        end
        r.vx = walk_voxel[0];
        r.vy = walk_voxel[1];
        r.vz = walk_voxel[2];
        r.hit = 1'b1;
        k = 0;
        if (walk_cross[1] < walk_cross[k])
            k = 1;
        if (walk_cross[2] < walk_cross[k])
            k = 2;
        if (walk_dir[k] == DIR_PLUS)
            walk_voxel[k] = walk_voxel[k] + 32'd1;
        else if (walk_dir[k] == DIR_MINUS)
            walk_voxel[k] = walk_voxel[k] - 32'd1;
        t = {1'b0, walk_cross[k]} + {1'b0, walk_inc[k]};
        walk_cross[k] = t[32] ? 32'hFFFF_FFFF : t[31:0];
        if (walk_taken >= walk_total)
            walk_done = 1'b1;
        else
            walk_taken = walk_taken + 32'd1;
    endtask

    // Offer one transaction and predict its result on acceptance
    task automatic send_item(input logic c, input logic [31:0] ox, oy, oz, px, py, pz,
                             input logic clr);
        voxel_res_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd = c;
        origin_x = ox;
        origin_y = oy;
        origin_z = oz;
        point_x = px;
        point_y = py;
        point_z = pz;
        clearing = clr;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == CMD_LOAD)
        begin
            setup_ray(ox, oy, oz, px, py, pz, clr);
            n_loads++;
        end
        else
        begin
            step_ray(r);
            voxel_queue.push_back(r);
            n_nexts++;
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_next(input int count);
        for (int i = 0; i < count; i++)
            send_item(CMD_NEXT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      1'($urandom));
    endtask

    // Hold until results are drained and the engine has finished any load
    task automatic wait_idle();
        while (voxel_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [30:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CARVING:     sh_carving = val[0];
            CFG_MAX_LEN:     sh_max_len = val;
            CFG_VOXEL_INV:   sh_voxel_inv = val;
            CFG_BAND:        sh_band = val;
            CFG_FROM_ORIGIN: sh_from_origin = val[0];
            default: ;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_all_cfg(input logic carve, input logic [30:0] max_len,
                               input logic [30:0] vinv, input logic [30:0] band,
                               input logic fwd);
        wait_idle();
        write_cfg(CFG_CARVING, {30'($urandom), carve});
        write_cfg(CFG_MAX_LEN, max_len);
        write_cfg(CFG_VOXEL_INV, vinv);
        write_cfg(CFG_BAND, band);
        write_cfg(CFG_FROM_ORIGIN, {30'($urandom), fwd});
    endtask

    // Load a random ray, mostly short ones that run to exhaustion
    task automatic random_ray();
        logic [31:0] o [3];
        logic [31:0] p [3];
        int          sel;
        for (int i = 0; i < 3; i++)
        begin
            sel = $urandom_range(99);
            o[i] = (sel < 70) ? 32'($signed($urandom_range(2097152)) - 1048576) : $urandom;
            sel = $urandom_range(99);
            if (sel < 15)
                p[i] = o[i];
            else if (sel < 88)
                p[i] = o[i] + 32'($signed($urandom_range(262144)) - 131072);
            else
                p[i] = $urandom;
        end
        send_item(CMD_LOAD, o[0], o[1], o[2], p[0], p[1], p[2], 1'($urandom));
        send_next($urandom_range(1, 30));
    endtask

    task automatic random_phase(input int items);
        int start;
        start = n_loads + n_nexts;
        while (n_loads + n_nexts - start < items)
            random_ray();
    endtask

    task automatic test_reset_state();
        send_next(3);
    endtask

    task automatic test_directed_rays();
        // Point equals origin
        send_item(CMD_LOAD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
        send_next(2);
        // Short ray along +x
        send_item(CMD_LOAD, 0, 0, 0, 32'h0000_8000, 0, 0, 1'b0);
        send_next(12);
        // Diagonal, equal crossing times on all axes
        send_item(CMD_LOAD, 0, 0, 0, 32'hFFFF_C000, 32'hFFFF_C000, 32'hFFFF_C000, 1'b0);
        send_next(14);
        // Clearing ray shorter than the band
        send_item(CMD_LOAD, 32'h0000_1000, 0, 0, 32'h0000_1100, 0, 0, 1'b1);
        send_next(3);
        // Clearing ray capped at the maximum length
        send_item(CMD_LOAD, 0, 0, 0, 32'h0001_0000, 32'h00C0_0000, 0, 1'b1);
        send_next(4);
        // Field extremes
        send_item(CMD_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_next(4);
    endtask

    task automatic test_cfg_extremes();
        // No carving, walk reversed, wide band
        set_all_cfg(1'b0, 31'h7FFF_FFFF, 31'd65536, 31'd40000, 1'b0);
        send_item(CMD_LOAD, 32'h0000_4000, 32'hFFFF_0000, 0, 32'h0003_0000, 0, 32'h0001_8000, 1'b0);
        send_next(10);
        send_item(CMD_LOAD, 0, 0, 0, 32'h0004_0000, 32'h0001_0000, 0, 1'b1);
        send_next(8);
        // Zero scale: one index then done
        set_all_cfg(1'b1, 31'd0, 31'd0, 31'd0, 1'b1);
        send_item(CMD_LOAD, 32'h1234_5678, 0, 0, 32'hFEDC_BA98, 1, 2, 1'b0);
        send_next(3);
        send_item(CMD_LOAD, 0, 0, 0, 32'h0002_0000, 0, 0, 1'b1);
        send_next(3);
        // Largest scale and band
        set_all_cfg(1'b0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send_item(CMD_LOAD, 32'h7FFF_0000, 32'h8000_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0000_0001, 1'b0);
        send_next(6);
        send_item(CMD_LOAD, 0, 0, 0, 32'h0000_0010, 32'h0000_0008, 0, 1'b1);
        send_next(6);
    endtask

    task automatic test_random_traffic();
        set_all_cfg(1'b1, 31'd327680, 31'd1310720, 31'd6554, 1'b1);
        idle_pct = 0;
        stall_pct = 0;
        random_phase(200);
        set_all_cfg(1'b0, 31'd131072, 31'd655360, 31'd3000, 1'b0);
        idle_pct = 55;
        stall_pct = 0;
        random_phase(200);
        set_all_cfg(1'b1, 31'($urandom_range(1 << 20)), 31'($urandom_range(1 << 21, 1)),
                    31'($urandom_range(1 << 16)), 1'b0);
        idle_pct = 0;
        stall_pct = 55;
        random_phase(200);
        set_all_cfg(1'b0, 31'($urandom), 31'($urandom_range(1 << 21, 1)),
                    31'($urandom_range(1 << 17)), 1'b1);
        idle_pct = 25;
        stall_pct = 25;
        random_phase(200);
    endtask

    task automatic test_backpressure();
        set_all_cfg(1'b1, 31'd327680, 31'd1310720, 31'd6554, 1'b1);
        idle_pct = 0;
        stall_pct = 0;
        // Block the receiver while the sender keeps going
        hold_left = 1500;
        send_item(CMD_LOAD, 0, 0, 0, 32'h0001_8000, 32'hFFFF_4000, 32'h0000_9000, 1'b0);
        send_next(20);
        // Pause the sender until every result is back
        while (voxel_queue.size() != 0)
            @(negedge clk);
        send_next(5);
    endtask

    // Receiver stall, with an optional long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall = 1'b1;
            end
            else
                out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        voxel_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (voxel_queue.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d valid_res=%0d",
                         $time, voxel_x, voxel_y, voxel_z, valid_res);
                errors++;
            end
            else
            begin
                want = voxel_queue.pop_front();
                n_checked++;
                if (voxel_x !== want.vx)
                begin
                    $display("%0t: voxel_x expected %0d actual %0d", $time,
                             $signed(want.vx), voxel_x);
                    errors++;
                end
                if (voxel_y !== want.vy)
                begin
                    $display("%0t: voxel_y expected %0d actual %0d", $time,
                             $signed(want.vy), voxel_y);
                    errors++;
                end
                if (voxel_z !== want.vz)
                begin
                    $display("%0t: voxel_z expected %0d actual %0d", $time,
                             $signed(want.vz), voxel_z);
                    errors++;
                end
                if (valid_res !== want.hit)
                begin
                    $display("%0t: valid_res expected %0d actual %0d", $time,
                             want.hit, valid_res);
                    errors++;
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, voxel_queue.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_LOAD;
        origin_x = '0;
        origin_y = '0;
        origin_z = '0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        clearing = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CARVING;
        cfg_data = '0;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        n_loads = 0;
        n_nexts = 0;
        n_checked = 0;
        n_cfg = 0;
        sh_carving = CARVING_RST;
        sh_max_len = MAX_LEN_RST;
        sh_voxel_inv = VOXEL_INV_RST;
        sh_band = BAND_RST;
        sh_from_origin = FROM_ORIGIN_RST;
        for (int i = 0; i < 3; i++)
        begin
            walk_voxel[i] = '0;
            walk_dir[i] = DIR_NONE;
            walk_cross[i] = '0;
            walk_inc[i] = '0;
        end
        walk_taken = '0;
        walk_total = '0;
        walk_done = 1'b1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_directed_rays();
        test_cfg_extremes();
        test_random_traffic();
        test_backpressure();

        // Drain and let the engine settle
        while (voxel_queue.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        $display("Sent %0d ray loads and %0d next requests, checked %0d voxel results,",
                 n_loads, n_nexts, n_checked);
        $display("with %0d register writes across carving, direction, band and scale settings.",
                 n_cfg);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> voxel_ray_traversal.f
hw/rtl/vrt_pkg.sv
hw/rtl/vrt_front.sv
hw/rtl/vrt_div.sv
hw/rtl/vrt_back.sv
hw/rtl/voxel_ray_traversal.sv
dv/tb_voxel_ray_traversal.sv
